@@ sv/assert_macros.svh @@
// Assertion macros for the RTL modules; ibc_ctrl is the one that uses them.
// The macros expect signals named clk and rst in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ sv/ibc_pkg.sv @@
// Package for the IMU bias calibrate-and-correct block: widths, codes, types.
// No dependencies; every other file of the block but assert_macros.svh imports it.
package ibc_pkg;

  localparam int ACCUM_WIDTH = 28;
  localparam int COUNT_WIDTH = 10;
  localparam int DATA_W      = 16;
  localparam int NUM_AXES    = 6;
  localparam int CALIB_W     = 10;
  localparam int GRAV_W      = 15;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int DIV_CNT_W   = $clog2(ACCUM_WIDTH);

  localparam logic [CFG_IDX_W-1:0] REG_CALIB_SAMPLES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_COUNTS = 2'd1;

  localparam logic [CALIB_W-1:0] CALIB_SAMPLES_RESET  = 10'd200;
  localparam logic [GRAV_W-1:0]  GRAVITY_COUNTS_RESET = 15'd16384;

  localparam int SAT_POS = 32767;
  localparam int SAT_NEG_MAG = 32768;

  typedef logic signed [DATA_W-1:0]      word_t;
  typedef logic signed [ACCUM_WIDTH-1:0] acc_t;
  typedef logic [COUNT_WIDTH-1:0]        count_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_COMMIT
  } state_t;

  // Axis order: accel x, y, z, then gyro x, y, z.
  typedef struct packed {
    logic [NUM_AXES-1:0][DATA_W-1:0] axis;
    logic                            accel_ok;
    logic                            gyro_ok;
  } sample_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][DATA_W-1:0] axis;
    logic                            calibrating;
  } result_t;

  typedef struct packed {
    logic load_out;
    logic calib_flag;
    logic clear_run;
    logic accumulate;
    logic div_load;
    logic div_step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_status_t;

  function automatic word_t sat16(input logic signed [DATA_W:0] v);
    word_t r;
    if (v > (DATA_W+1)'(SAT_POS)) begin
      r = word_t'(SAT_POS);
    end else if (v < -(DATA_W+1)'(SAT_NEG_MAG)) begin
      r = word_t'(-SAT_NEG_MAG);
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ sv/ibc_if.sv @@
// Channel interfaces of the IMU bias block: sample in, result out, config write.
// Depends on ibc_pkg for the field widths.
interface ibc_in_if import ibc_pkg::*;;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [DATA_W-1:0] accel_x_raw;
  logic [DATA_W-1:0] accel_y_raw;
  logic [DATA_W-1:0] accel_z_raw;
  logic [DATA_W-1:0] gyro_x_raw;
  logic [DATA_W-1:0] gyro_y_raw;
  logic [DATA_W-1:0] gyro_z_raw;
  logic              accel_ok;
  logic              gyro_ok;

  modport source (output valid, cmd, accel_x_raw, accel_y_raw, accel_z_raw,
                  gyro_x_raw, gyro_y_raw, gyro_z_raw, accel_ok, gyro_ok,
                  input ready);
  modport sink (input valid, cmd, accel_x_raw, accel_y_raw, accel_z_raw,
                gyro_x_raw, gyro_y_raw, gyro_z_raw, accel_ok, gyro_ok,
                output ready);
endinterface

interface ibc_out_if import ibc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] accel_x_out;
  logic [DATA_W-1:0] accel_y_out;
  logic [DATA_W-1:0] accel_z_out;
  logic [DATA_W-1:0] gyro_x_out;
  logic [DATA_W-1:0] gyro_y_out;
  logic [DATA_W-1:0] gyro_z_out;
  logic              calibrating;

  modport source (output valid, accel_x_out, accel_y_out, accel_z_out,
                  gyro_x_out, gyro_y_out, gyro_z_out, calibrating,
                  input ready);
  modport sink (input valid, accel_x_out, accel_y_out, accel_z_out,
                gyro_x_out, gyro_y_out, gyro_z_out, calibrating,
                output ready);
endinterface

interface ibc_cfg_if import ibc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/ibc_div_lane.sv @@
// One restoring-division lane: magnitude of a signed sum over a good-sample
// count, one quotient bit per step, giving the saturated negated mean. Uses ibc_pkg.
module ibc_div_lane import ibc_pkg::*; (
  input  logic   clk,
  input  logic   load,
  input  logic   step,
  input  acc_t   dividend,
  input  count_t divisor,
  output word_t  offset
);

  logic                   neg;
  logic [ACCUM_WIDTH-1:0] quo;
  count_t                 rem;
  logic [COUNT_WIDTH:0]   trial;
  logic                   fits;
  logic [DATA_W-1:0]      mag16;

  assign trial = {rem, quo[ACCUM_WIDTH-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign mag16 = quo[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (load) begin
      neg <= dividend[ACCUM_WIDTH-1];
      quo <= dividend[ACCUM_WIDTH-1] ? ACCUM_WIDTH'(-dividend) : ACCUM_WIDTH'(dividend);
      rem <= '0;
    end else if (step) begin
      rem <= fits ? COUNT_WIDTH'(trial - {1'b0, divisor}) : trial[COUNT_WIDTH-1:0];
      quo <= {quo[ACCUM_WIDTH-2:0], fits};
    end
  end

  // The mean truncates toward zero, so its negation is +mag for a negative sum
  // and -mag for a positive one.
  always_comb begin
    if (neg) begin
      offset = (quo > ACCUM_WIDTH'(SAT_POS)) ? word_t'(SAT_POS) : word_t'(mag16);
    end else begin
      offset = (quo > ACCUM_WIDTH'(SAT_NEG_MAG)) ? word_t'(-SAT_NEG_MAG)
                                                 : word_t'(DATA_W'(0) - mag16);
    end
  end

endmodule

@@ sv/ibc_datapath.sv @@
// Datapath: offset correction and saturation, run sums and counts, six
// division lanes, offset registers and the result register. Uses ibc_pkg, ibc_div_lane.
module ibc_datapath import ibc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ctrl_cmd_t         ctl,
  output dp_status_t        status,
  input  sample_t           sample_in,
  input  logic [GRAV_W-1:0] gravity_counts,
  output result_t           result
);

  word_t              raw    [NUM_AXES];
  word_t              corr   [NUM_AXES];
  word_t              offset [NUM_AXES];
  word_t              div_res[NUM_AXES];
  acc_t               sum    [NUM_AXES];
  acc_t               addend [NUM_AXES];
  count_t             accel_cnt;
  count_t             gyro_cnt;
  logic [DIV_CNT_W-1:0] step_cnt;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      raw[i]    = sample_in.axis[i];
      corr[i]   = sat16((DATA_W+1)'(raw[i]) + (DATA_W+1)'(offset[i]));
      addend[i] = ACCUM_WIDTH'(corr[i]);
    end
    // Accel Z loses one g while it is summed.
    addend[2] = ACCUM_WIDTH'(corr[2]) - acc_t'(ACCUM_WIDTH'(gravity_counts));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        offset[i] <= '0;
        sum[i]    <= '0;
      end
      accel_cnt <= '0;
      gyro_cnt  <= '0;
    end else if (ctl.clear_run) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        offset[i] <= '0;
        sum[i]    <= '0;
      end
      accel_cnt <= '0;
      gyro_cnt  <= '0;
    end else if (ctl.accumulate) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        if ((i < 3) ? sample_in.accel_ok : sample_in.gyro_ok) begin
          sum[i] <= sum[i] + addend[i];
        end
      end
      if (sample_in.accel_ok) begin
        accel_cnt <= accel_cnt + 1'b1;
      end
      if (sample_in.gyro_ok) begin
        gyro_cnt <= gyro_cnt + 1'b1;
      end
    end else if (ctl.commit) begin
      // A sensor without a good sample keeps its cleared offsets.
      for (int i = 0; i < NUM_AXES; i++) begin
        if ((i < 3) ? (accel_cnt != '0) : (gyro_cnt != '0)) begin
          offset[i] <= div_res[i];
        end
      end
    end
  end

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    ibc_div_lane u_lane (
      .clk      (clk),
      .load     (ctl.div_load),
      .step     (ctl.div_step),
      .dividend (sum[g]),
      .divisor  ((g < 3) ? accel_cnt : gyro_cnt),
      .offset   (div_res[g])
    );
  end

  always_ff @(posedge clk) begin
    if (ctl.div_load) begin
      step_cnt <= '0;
    end else if (ctl.div_step) begin
      step_cnt <= step_cnt + 1'b1;
    end
  end

  assign status.div_last = (step_cnt == DIV_CNT_W'(ACCUM_WIDTH - 1));

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        result.axis[i] <= corr[i];
      end
      result.calibrating <= ctl.calib_flag;
    end
  end

endmodule

@@ sv/ibc_ctrl.sv @@
// Controller: handshakes, run counter, calibration flag and the sequencing of
// the end-of-run division. Uses ibc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ibc_ctrl import ibc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_ready,
  input  logic               sample_cmd,
  output logic               result_valid,
  input  logic               result_ready,
  input  logic [CALIB_W-1:0] calib_samples,
  input  dp_status_t         status,
  output ctrl_cmd_t          ctl
);

  state_t state, state_next;
  count_t samples_left, samples_left_next;
  logic   calib_active, calib_active_next;
  logic   result_valid_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      samples_left <= '0;
      calib_active <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      samples_left <= samples_left_next;
      calib_active <= calib_active_next;
      result_valid <= result_valid_next;
    end
  end

  always_comb begin
    sample_ready      = (state == ST_IDLE) && (!result_valid || result_ready);
    accept            = sample_valid && sample_ready;
    state_next        = state;
    samples_left_next = samples_left;
    calib_active_next = calib_active;
    result_valid_next = accept ? 1'b1 : (result_ready ? 1'b0 : result_valid);
    ctl               = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          ctl.load_out = 1'b1;
          if (sample_cmd) begin
            ctl.clear_run     = 1'b1;
            samples_left_next = COUNT_WIDTH'(calib_samples);
            calib_active_next = (COUNT_WIDTH'(calib_samples) != '0);
          end else if (calib_active) begin
            ctl.accumulate    = 1'b1;
            samples_left_next = samples_left - 1'b1;
            if (samples_left == count_t'(1)) begin
              calib_active_next = 1'b0;
              state_next        = ST_LOAD;
            end
          end
          ctl.calib_flag = calib_active_next;
        end
      end
      ST_LOAD: begin
        ctl.div_load = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        ctl.commit = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `ASSERT_IMP(a_active_has_samples, calib_active, samples_left != '0)
  `ASSERT_NXT(a_last_item_divides,
              accept && !sample_cmd && calib_active && samples_left == count_t'(1),
              state == ST_LOAD && !calib_active)
  `ASSERT_IMP(a_commit_after_div, state == ST_COMMIT, $past(state) == ST_DIV)
  `ASSERT_IMP(a_no_accept_in_run_end, state != ST_IDLE, !sample_ready)

endmodule

@@ sv/imu_bias_calibrate_correct.sv @@
// Top level of the IMU bias calibrate-and-correct block: configuration
// registers and channel wiring. Uses ibc_pkg, ibc_if, ibc_ctrl, ibc_datapath.
//
//   channel   direction  handshake        payload
//   sample    in         valid / ready    cmd, six raw axes, accel_ok, gyro_ok
//   result    out        valid / ready    six corrected axes, calibrating
//   cfg       in         valid / ready    index, data (always ready)
//
// An ordinary item's result sits in the output register, and the next item is
// taken as that result is transferred. The item that ends a calibration run is
// followed by the load, divide and commit states, in which six shared-step
// division lanes form the offsets. rst is synchronous: offsets, sums and counts
// clear, no run is active. A stalled result holds the block: no sample is taken
// until it is transferred.
module imu_bias_calibrate_correct import ibc_pkg::*; (
  input logic      clk,
  input logic      rst,
  ibc_in_if.sink   sample,
  ibc_out_if.source result,
  ibc_cfg_if.sink  cfg
);

  logic [CALIB_W-1:0] calib_samples;
  logic [GRAV_W-1:0]  gravity_counts;
  ctrl_cmd_t          ctl;
  dp_status_t         status;
  sample_t            sample_in;
  result_t            result_reg;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      calib_samples  <= CALIB_SAMPLES_RESET;
      gravity_counts <= GRAVITY_COUNTS_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CALIB_SAMPLES:  calib_samples  <= cfg.data[CALIB_W-1:0];
        REG_GRAVITY_COUNTS: gravity_counts <= cfg.data[GRAV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign sample_in.axis[0]  = sample.accel_x_raw;
  assign sample_in.axis[1]  = sample.accel_y_raw;
  assign sample_in.axis[2]  = sample.accel_z_raw;
  assign sample_in.axis[3]  = sample.gyro_x_raw;
  assign sample_in.axis[4]  = sample.gyro_y_raw;
  assign sample_in.axis[5]  = sample.gyro_z_raw;
  assign sample_in.accel_ok = sample.accel_ok;
  assign sample_in.gyro_ok  = sample.gyro_ok;

  ibc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample.valid),
    .sample_ready  (sample.ready),
    .sample_cmd    (sample.cmd),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .calib_samples (calib_samples),
    .status        (status),
    .ctl           (ctl)
  );

  ibc_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .status         (status),
    .sample_in      (sample_in),
    .gravity_counts (gravity_counts),
    .result         (result_reg)
  );

  assign result.accel_x_out = result_reg.axis[0];
  assign result.accel_y_out = result_reg.axis[1];
  assign result.accel_z_out = result_reg.axis[2];
  assign result.gyro_x_out  = result_reg.axis[3];
  assign result.gyro_y_out  = result_reg.axis[4];
  assign result.gyro_z_out  = result_reg.axis[5];
  assign result.calibrating = result_reg.calibrating;

endmodule

@@ tb/imu_bias_calibrate_correct_tb.sv @@
// Self-checking testbench for imu_bias_calibrate_correct: directed corner items, then random
// calibration runs under random sender gaps and receiver stalls, checked against a predictor.
// Depends on ibc_pkg and the channel interfaces in ibc_if.
module imu_bias_calibrate_correct_tb;
  import ibc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_BUDGET = 1150;
  localparam int LONG_RUN_AT = 100;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_B = 2'd3;

  typedef struct packed {
    logic    start;
    sample_t s;
  } imu_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE} stall_mode_t;

  logic clk;
  logic rst;

  ibc_in_if  sample_ch ();
  ibc_out_if result_ch ();
  ibc_cfg_if cfg_ch ();

  imu_bias_calibrate_correct dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  imu_item_t  imu_items [$];
  reg_write_t cfg_writes [$];
  result_t    expected_results [$];

  imu_item_t   on_wire = '0;
  logic        sample_taken = 1'b0;
  logic        cfg_taken = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_span = 0;
  stall_mode_t stall_mode = READY_ALWAYS;
  int          items_queued = 0;
  int          mismatches = 0;
  int          cycle_count = 0;

  string axis_name [NUM_AXES] = '{"accel_x_out", "accel_y_out", "accel_z_out",
                                  "gyro_x_out", "gyro_y_out", "gyro_z_out"};

  // Predictor state: axes 0..2 are accel, 3..5 gyro; sensor 0 is accel, 1 is gyro.
  word_t                bias [NUM_AXES];
  acc_t                 total [NUM_AXES];
  count_t               hits [2];
  count_t               samples_to_go;
  logic                 run_open;
  logic [CALIB_W-1:0]   calib_len_cfg;
  logic [GRAV_W-1:0]    gravity_cfg;

  function automatic word_t clamp16(longint v);
    if (v > longint'(SAT_POS)) return word_t'(SAT_POS);
    if (v < -longint'(SAT_NEG_MAG)) return word_t'(-SAT_NEG_MAG);
    return word_t'(v);
  endfunction

  function automatic void clear_calibration();
    for (int i = 0; i < NUM_AXES; i++) begin
      bias[i] = '0;
      total[i] = '0;
    end
    hits[0] = '0;
    hits[1] = '0;
  endfunction

  function automatic result_t correct_and_calibrate(imu_item_t it);
    result_t r;
    word_t   fixed [NUM_AXES];
    logic    ok;
    int      term;
    // Corrections use the offsets as they stood before this item.
    for (int i = 0; i < NUM_AXES; i++)
      fixed[i] = clamp16(longint'(word_t'(it.s.axis[i])) + longint'(bias[i]));
    if (it.start) begin
      clear_calibration();
      samples_to_go = calib_len_cfg;
      run_open = (calib_len_cfg != 0);
    end else if (run_open) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        ok = (i < 3) ? it.s.accel_ok : it.s.gyro_ok;
        if (ok) begin
          term = int'(fixed[i]) - ((i == 2) ? int'(gravity_cfg) : 0);
          total[i] = total[i] + acc_t'(term);
        end
      end
      if (it.s.accel_ok) hits[0] = hits[0] + 1'b1;
      if (it.s.gyro_ok) hits[1] = hits[1] + 1'b1;
      samples_to_go = samples_to_go - 1'b1;
      if (samples_to_go == 0) begin
        // A sensor without a single good sample keeps its cleared offsets.
        for (int i = 0; i < NUM_AXES; i++)
          if (hits[i / 3] != 0)
            bias[i] = clamp16(-(longint'(total[i]) / longint'(hits[i / 3])));
        run_open = 1'b0;
      end
    end
    for (int i = 0; i < NUM_AXES; i++) r.axis[i] = fixed[i];
    r.calibrating = run_open;
    return r;
  endfunction

  function automatic void queue_item(imu_item_t it);
    imu_items.push_back(it);
    items_queued++;
  endfunction

  function automatic imu_item_t flat_item(logic start, int accel, int gyro, logic aok, logic gok);
    imu_item_t it;
    it.start = start;
    for (int i = 0; i < 3; i++) begin
      it.s.axis[i] = word_t'(accel);
      it.s.axis[3 + i] = word_t'(gyro);
    end
    it.s.accel_ok = aok;
    it.s.gyro_ok = gok;
    return it;
  endfunction

  task automatic wait_until_idle();
    do @(posedge clk);
    while (imu_items.size() != 0 || sample_ch.valid || expected_results.size() != 0 ||
           cfg_writes.size() != 0 || cfg_ch.valid);
  endtask

  task automatic queue_random_phase(input logic long_run);
    int                 centre [NUM_AXES];
    int                 spread;
    int                 accel_rate;
    int                 gyro_rate;
    int                 run_items;
    int                 r;
    logic [CALIB_W-1:0] len;
    logic [GRAV_W-1:0]  grav;
    imu_item_t          it;
    r = $urandom_range(0, 19);
    if (long_run) len = '1;
    else if (r == 0) len = '0;
    else if (r == 1) len = CALIB_W'(1);
    else if (r < 4) len = CALIB_W'($urandom_range(16, 64));
    else len = CALIB_W'($urandom_range(2, 12));
    r = $urandom_range(0, 7);
    if (r == 0) grav = '0;
    else if (r == 1) grav = '1;
    else if (r == 2) grav = GRAVITY_COUNTS_RESET;
    else grav = GRAV_W'($urandom);
    cfg_writes.push_back('{REG_CALIB_SAMPLES, {(CFG_DATA_W - CALIB_W)'($urandom), len}});
    cfg_writes.push_back('{REG_GRAVITY_COUNTS, {(CFG_DATA_W - GRAV_W)'($urandom), grav}});
    if ($urandom_range(0, 5) == 0)
      cfg_writes.push_back('{$urandom_range(0, 1) ? REG_UNMAPPED_A : REG_UNMAPPED_B,
                             CFG_DATA_W'($urandom)});
    wait_until_idle();

    if (!long_run && $urandom_range(0, 9) == 0) begin
      // Unstructured traffic: stray starts, arbitrary flags and readings.
      repeat ($urandom_range(4, 16)) begin
        it.start = ($urandom_range(0, 7) == 0);
        it.s.axis = {$urandom, $urandom, $urandom};
        it.s.accel_ok = 1'($urandom);
        it.s.gyro_ok = 1'($urandom);
        queue_item(it);
      end
    end else begin
      r = $urandom_range(0, 5);
      spread = (r == 0) ? 0 : (r == 1 && !long_run) ? 65535 : $urandom_range(1, 500);
      for (int i = 0; i < NUM_AXES; i++) begin
        r = $urandom_range(0, 7);
        if (r == 0) centre[i] = -SAT_NEG_MAG;
        else if (r == 1) centre[i] = SAT_POS;
        else centre[i] = int'($urandom_range(0, 65535)) - SAT_NEG_MAG;
      end
      if ($urandom_range(0, 1)) centre[2] = int'(grav);
      r = $urandom_range(0, 5);
      accel_rate = (r == 0) ? 0 : (r == 1) ? 2 : (r == 2) ? 3 : 4;
      r = $urandom_range(0, 5);
      gyro_rate = (r == 0) ? 0 : (r == 1) ? 2 : (r == 2) ? 3 : 4;
      // Some runs are cut short so that they stay open across a register write.
      if (len == 0) run_items = $urandom_range(1, 4);
      else if (!long_run && $urandom_range(0, 9) == 0) run_items = $urandom_range(0, len);
      else run_items = len;
      run_items += $urandom_range(1, 6);
      it.start = 1'b1;
      it.s.axis = {$urandom, $urandom, $urandom};
      it.s.accel_ok = 1'($urandom);
      it.s.gyro_ok = 1'($urandom);
      queue_item(it);
      repeat (run_items) begin
        it.start = 1'b0;
        for (int i = 0; i < NUM_AXES; i++)
          it.s.axis[i] = clamp16(longint'(centre[i]) +
                                 longint'($urandom_range(0, 2 * spread)) - spread);
        it.s.accel_ok = ($urandom_range(0, 3) < accel_rate);
        it.s.gyro_ok = ($urandom_range(0, 3) < gyro_rate);
        queue_item(it);
      end
    end
  endtask

  initial begin : clock_gen
    clk = 1'b0;
    rst = 1'b1;
    sample_ch.valid = 1'b0;
    sample_ch.cmd = 1'b0;
    sample_ch.accel_x_raw = '0;
    sample_ch.accel_y_raw = '0;
    sample_ch.accel_z_raw = '0;
    sample_ch.gyro_x_raw = '0;
    sample_ch.gyro_y_raw = '0;
    sample_ch.gyro_z_raw = '0;
    sample_ch.accel_ok = 1'b0;
    sample_ch.gyro_ok = 1'b0;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    forever #10 clk = ~clk;
  end

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin : sample_driver
    imu_item_t head_item;
    if (!sample_ch.valid || sample_taken) begin
      if (gap_left > 0 || imu_items.size() == 0) begin
        if (gap_left > 0) gap_left--;
        sample_ch.valid <= 1'b0;
      end else begin
        head_item = imu_items.pop_front();
        on_wire <= head_item;
        sample_ch.cmd <= head_item.start;
        sample_ch.accel_x_raw <= head_item.s.axis[0];
        sample_ch.accel_y_raw <= head_item.s.axis[1];
        sample_ch.accel_z_raw <= head_item.s.axis[2];
        sample_ch.gyro_x_raw <= head_item.s.axis[3];
        sample_ch.gyro_y_raw <= head_item.s.axis[4];
        sample_ch.gyro_z_raw <= head_item.s.axis[5];
        sample_ch.accel_ok <= head_item.s.accel_ok;
        sample_ch.gyro_ok <= head_item.s.gyro_ok;
        sample_ch.valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  always @(negedge clk) begin : cfg_driver
    reg_write_t head_write;
    if (!cfg_ch.valid || cfg_taken) begin
      if (cfg_writes.size() != 0) begin
        head_write = cfg_writes.pop_front();
        cfg_ch.index <= head_write.index;
        cfg_ch.data <= head_write.data;
        cfg_ch.valid <= 1'b1;
      end else begin
        cfg_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: stretches of steady readiness, coin-flip readiness and heavy stalling.
  always @(negedge clk) begin : result_stall
    if (stall_span == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      stall_span = $urandom_range(8, 64);
    end else begin
      stall_span--;
    end
    case (stall_mode)
      READY_ALWAYS: result_ch.ready <= 1'b1;
      READY_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
      default:      result_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (rst) begin
      sample_taken <= 1'b0;
      cfg_taken <= 1'b0;
      calib_len_cfg = CALIB_SAMPLES_RESET;
      gravity_cfg = GRAVITY_COUNTS_RESET;
      clear_calibration();
      samples_to_go = '0;
      run_open = 1'b0;
    end else begin
      sample_taken <= sample_ch.valid && sample_ch.ready;
      cfg_taken <= cfg_ch.valid && cfg_ch.ready;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_CALIB_SAMPLES:  calib_len_cfg = cfg_ch.data[CALIB_W-1:0];
          REG_GRAVITY_COUNTS: gravity_cfg = cfg_ch.data[GRAV_W-1:0];
          default: ;
        endcase
      end
      if (sample_ch.valid && sample_ch.ready)
        expected_results.push_back(correct_and_calibrate(on_wire));
      if (result_ch.valid && result_ch.ready) begin
        got.axis[0] = result_ch.accel_x_out;
        got.axis[1] = result_ch.accel_y_out;
        got.axis[2] = result_ch.accel_z_out;
        got.axis[3] = result_ch.gyro_x_out;
        got.axis[4] = result_ch.gyro_y_out;
        got.axis[5] = result_ch.gyro_z_out;
        got.calibrating = result_ch.calibrating;
        if (expected_results.size() == 0) begin
          $error("result transfer with no expected result pending");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          for (int i = 0; i < NUM_AXES; i++) begin
            if (got.axis[i] !== want.axis[i]) begin
              $error("%s: expected %0d, got %0d", axis_name[i],
                     $signed(want.axis[i]), $signed(got.axis[i]));
              mismatches++;
            end
          end
          if (got.calibrating !== want.calibrating) begin
            $error("calibrating: expected %0b, got %0b", want.calibrating, got.calibrating);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("imu_bias_calibrate_correct_tb failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic long_done;
    long_done = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Two-sample runs; full-scale gravity drives the accel Z mean out of range.
    cfg_writes.push_back('{REG_CALIB_SAMPLES, CFG_DATA_W'(2)});
    cfg_writes.push_back('{REG_GRAVITY_COUNTS, CFG_DATA_W'(SAT_POS)});
    wait_until_idle();
    queue_item(flat_item(1'b0, -SAT_NEG_MAG, -SAT_NEG_MAG, 1'b1, 1'b1));
    queue_item(flat_item(1'b0, SAT_POS, SAT_POS, 1'b0, 1'b0));
    queue_item(flat_item(1'b1, 12345, -12345, 1'b1, 1'b1));
    queue_item(flat_item(1'b0, -SAT_NEG_MAG, -SAT_NEG_MAG, 1'b1, 1'b1));
    queue_item(flat_item(1'b0, -SAT_NEG_MAG, -SAT_NEG_MAG, 1'b1, 1'b1));
    // Offsets are now saturated high, so positive full-scale readings clip.
    queue_item(flat_item(1'b0, SAT_POS, SAT_POS, 1'b1, 1'b1));
    queue_item(flat_item(1'b0, -SAT_NEG_MAG, -SAT_NEG_MAG, 1'b0, 1'b1));
    queue_item(flat_item(1'b1, SAT_POS, SAT_POS, 1'b1, 1'b1));
    queue_item(flat_item(1'b0, SAT_POS, SAT_POS, 1'b1, 1'b1));
    queue_item(flat_item(1'b0, SAT_POS, SAT_POS, 1'b1, 1'b0));
    queue_item(flat_item(1'b0, -SAT_NEG_MAG, -SAT_NEG_MAG, 1'b1, 1'b1));
    // A start in the middle of a run restarts it; odd sums check truncation.
    queue_item(flat_item(1'b1, 0, 0, 1'b1, 1'b1));
    queue_item(flat_item(1'b0, 100, -100, 1'b1, 1'b1));
    queue_item(flat_item(1'b1, 5, 5, 1'b1, 1'b1));
    queue_item(flat_item(1'b0, -7, 7, 1'b1, 1'b1));
    queue_item(flat_item(1'b0, -8, 9, 1'b1, 1'b1));
    queue_item(flat_item(1'b0, 0, 0, 1'b1, 1'b1));
    // Neither sensor reports a good sample, so the offsets stay cleared.
    queue_item(flat_item(1'b1, 1, 1, 1'b1, 1'b1));
    queue_item(flat_item(1'b0, 50, 60, 1'b0, 1'b0));
    queue_item(flat_item(1'b0, 70, 80, 1'b0, 1'b0));
    queue_item(flat_item(1'b0, 3, 4, 1'b1, 1'b1));
    wait_until_idle();

    // A zero sample count: the start clears offsets and no run opens.
    cfg_writes.push_back('{REG_CALIB_SAMPLES, CFG_DATA_W'(0)});
    cfg_writes.push_back('{REG_GRAVITY_COUNTS, CFG_DATA_W'(0)});
    cfg_writes.push_back('{REG_UNMAPPED_A, CFG_DATA_W'(16'hFFFF)});
    cfg_writes.push_back('{REG_UNMAPPED_B, CFG_DATA_W'(16'h5A5A)});
    wait_until_idle();
    queue_item(flat_item(1'b1, 9, 9, 1'b1, 1'b1));
    queue_item(flat_item(1'b0, 1000, 1000, 1'b1, 1'b1));
    wait_until_idle();

    while (items_queued < ITEM_BUDGET) begin
      if (!long_done && items_queued >= LONG_RUN_AT) begin
        queue_random_phase(1'b1);
        long_done = 1'b1;
      end else begin
        queue_random_phase(1'b0);
      end
      wait_until_idle();
    end

    // The last item may close a run, which adds the division pass.
    repeat (ACCUM_WIDTH + 8) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("imu_bias_calibrate_correct_tb passed");
    end else begin
      $display("imu_bias_calibrate_correct_tb failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/ibc_pkg.sv
sv/ibc_if.sv
sv/ibc_div_lane.sv
sv/ibc_datapath.sv
sv/ibc_ctrl.sv
sv/imu_bias_calibrate_correct.sv
tb/imu_bias_calibrate_correct_tb.sv
